// ===== sv/frac_pkg.sv =====
package frac_pkg;

	typedef logic [2:0] step_t;

	typedef enum logic [2:0] {
		OP_NONE     = 3'd0,
		OP_LOAD     = 3'd1,
		OP_SHIFT2   = 3'd2,
		OP_GCD      = 3'd3,
		OP_DIV_INIT = 3'd4,
		OP_DIV      = 3'd5,
		OP_RESULT   = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER     = 3'd0,
		C_NO_REQ    = 3'd1,
		C_ZERO      = 3'd2,
		C_BOTH_EVEN = 3'd3,
		C_A_NE_B    = 3'd4,
		C_DIV_MORE  = 3'd5,
		C_NO_ACK    = 3'd6
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic zero;
		logic both_even;
		logic a_ne_b;
		logic div_last;
	} flags_t;

	localparam step_t S_WAIT     = 3'd0;
	localparam step_t S_CHK      = 3'd1;
	localparam step_t S_TWOS     = 3'd2;
	localparam step_t S_GCD      = 3'd3;
	localparam step_t S_DIV_INIT = 3'd4;
	localparam step_t S_DIV      = 3'd5;
	localparam step_t S_RESULT   = 3'd6;
	localparam step_t S_OUT      = 3'd7;

	// taken condition jumps to target, otherwise fall through to the next step
	function automatic ucode_t ucode_rom(step_t pc);
		ucode_t w;
		unique case (pc)
			S_WAIT:     w = '{op: OP_LOAD,     cond: C_NO_REQ,    target: S_WAIT};
			S_CHK:      w = '{op: OP_NONE,     cond: C_ZERO,      target: S_OUT};
			S_TWOS:     w = '{op: OP_SHIFT2,   cond: C_BOTH_EVEN, target: S_TWOS};
			S_GCD:      w = '{op: OP_GCD,      cond: C_A_NE_B,    target: S_GCD};
			S_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEVER,     target: S_WAIT};
			S_DIV:      w = '{op: OP_DIV,      cond: C_DIV_MORE,  target: S_DIV};
			S_RESULT:   w = '{op: OP_RESULT,   cond: C_NEVER,     target: S_WAIT};
			S_OUT:      w = '{op: OP_NONE,     cond: C_NO_ACK,    target: S_OUT};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/frac_if.sv =====
interface frac_in_if #(parameter int W = 16) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] numerator;
	logic [W-1:0] denominator;

	modport source(output valid, numerator, denominator, input ready);
	modport sink(input valid, numerator, denominator, output ready);
endinterface

interface frac_out_if #(parameter int W = 16) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] reduced_numerator;
	logic [W-1:0] reduced_denominator;

	modport source(output valid, reduced_numerator, reduced_denominator, input ready);
	modport sink(input valid, reduced_numerator, reduced_denominator, output ready);
endinterface

// ===== sv/frac_dp.sv =====
module frac_dp #(
	parameter int W = 16
) (
	input  logic            clk,
	input  frac_pkg::op_t   op,
	input  logic [W-1:0]    numerator,
	input  logic [W-1:0]    denominator,
	output frac_pkg::flags_t flags,
	output logic [W-1:0]    reduced_numerator,
	output logic [W-1:0]    reduced_denominator
);
	import frac_pkg::*;

	localparam int CW = $clog2(W);

	logic [W-1:0]  n_q, d_q, a_q, b_q;
	logic [W-1:0]  qn_q, rn_q, qd_q, rd_q;
	logic [CW-1:0] cnt_q;

	logic [W:0] remn, remd, remn_sub, remd_sub;
	logic       gten, gted;

	// one restoring divide step per cycle for both operands, shared divisor
	assign remn     = {rn_q, qn_q[W-1]};
	assign remd     = {rd_q, qd_q[W-1]};
	assign remn_sub = remn - {1'b0, a_q};
	assign remd_sub = remd - {1'b0, a_q};
	assign gten     = remn >= {1'b0, a_q};
	assign gted     = remd >= {1'b0, a_q};

	assign flags.zero      = (n_q == '0) || (d_q == '0);
	assign flags.both_even = !n_q[0] && !d_q[0];
	assign flags.a_ne_b    = a_q != b_q;
	assign flags.div_last  = cnt_q == CW'(W - 1);

	assign reduced_numerator   = n_q;
	assign reduced_denominator = d_q;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				n_q <= numerator;
				d_q <= denominator;
			end
			OP_SHIFT2: begin
				// common twos cancel; odd-part gcd follows
				if (flags.both_even) begin
					n_q <= n_q >> 1;
					d_q <= d_q >> 1;
				end else begin
					a_q <= n_q;
					b_q <= d_q;
				end
			end
			OP_GCD: begin
				priority if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q > b_q) begin
					a_q <= a_q - b_q;
				end else if (b_q > a_q) begin
					b_q <= b_q - a_q;
				end else begin
					// equal: the loop leaves on this step
				end
			end
			OP_DIV_INIT: begin
				qn_q  <= n_q;
				qd_q  <= d_q;
				rn_q  <= '0;
				rd_q  <= '0;
				cnt_q <= '0;
			end
			OP_DIV: begin
				rn_q  <= gten ? remn_sub[W-1:0] : remn[W-1:0];
				rd_q  <= gted ? remd_sub[W-1:0] : remd[W-1:0];
				qn_q  <= {qn_q[W-2:0], gten};
				qd_q  <= {qd_q[W-2:0], gted};
				cnt_q <= cnt_q + CW'(1);
			end
			OP_RESULT: begin
				n_q <= qn_q;
				d_q <= qd_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/fraction_reducer.sv =====
// Reduces numerator/denominator to lowest terms, one transaction at a time; a pair with a
// zero in it comes back unchanged. A small microprogram steps a shift/subtract datapath:
// shared factors of two are stripped first, a binary gcd loop finds the odd divisor, then
// both values go through a bit-serial restoring divide of VALUE_WIDTH steps. A zero operand
// goes from the zero check straight to the output step; otherwise the result follows the
// twos, gcd, divide-init, divide and result steps in that order. The next transaction
// is taken in the cycle after the result is handed over.
module fraction_reducer #(
	parameter int VALUE_WIDTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	frac_in_if.sink   req,
	frac_out_if.source rsp
);
	import frac_pkg::*;

	step_t  pc_q;
	ucode_t uw;
	flags_t flags;
	logic   taken;

	assign uw = ucode_rom(pc_q);

	always_comb begin
		unique case (uw.cond)
			C_NEVER:     taken = 1'b0;
			C_NO_REQ:    taken = !req.valid;
			C_ZERO:      taken = flags.zero;
			C_BOTH_EVEN: taken = flags.both_even;
			C_A_NE_B:    taken = flags.a_ne_b;
			C_DIV_MORE:  taken = !flags.div_last;
			C_NO_ACK:    taken = !rsp.ready;
			default:     taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else begin
			pc_q <= taken ? uw.target : pc_q + step_t'(1);
		end
	end

	assign req.ready = pc_q == S_WAIT;
	assign rsp.valid = pc_q == S_OUT;

	frac_dp #(.W(VALUE_WIDTH)) u_dp (
		.clk                 (clk),
		.op                  (uw.op),
		.numerator           (req.numerator),
		.denominator         (req.denominator),
		.flags               (flags),
		.reduced_numerator   (rsp.reduced_numerator),
		.reduced_denominator (rsp.reduced_denominator)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("input taken while a result is pending");

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> pc_q == S_CHK)
		else $error("accepted transaction did not reach the zero check");

	a_gcd_exit: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == S_GCD && !flags.a_ne_b |=> pc_q == S_DIV_INIT)
		else $error("gcd loop did not hand over to the divider");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == S_DIV && !flags.div_last |=> pc_q == S_DIV)
		else $error("divider left early");

endmodule
